// ===== src/mked_pkg.sv =====
`default_nettype none
package mked_pkg;

   // Sizes of the decoder
   localparam int MAX_ELEMENTS = 8;
   localparam int TIMER_WIDTH  = 16;
   localparam int ELEM_IDX_W   = $clog2(MAX_ELEMENTS);
   localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

   // Register field widths
   localparam int DEBOUNCE_W = 8;
   localparam int DOT_W      = 15;
   localparam int GAP_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DOT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAP      = 2'd2;

   // Reset values of the registers
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd5;
   localparam logic [DOT_W-1:0]      DOT_RST      = 15'd60;
   localparam logic [GAP_W-1:0]      GAP_RST      = 16'd180;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef logic [TIMER_WIDTH-1:0] timer_type;
   typedef logic [COUNT_W-1:0]     count_type;

   localparam timer_type TIMER_MAX = '1;

   // Configuration seen by the decoder core
   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [DOT_W-1:0]      dot_ticks;
      logic [GAP_W-1:0]      char_gap_ticks;
   } cfg_type;

   // One result beat
   typedef struct packed {
      count_type                 pattern_len;
      logic [MAX_ELEMENTS-1:0]   pattern_bits;
      logic                      char_valid;
      logic                      element_dash;
      logic                      element_valid;
      logic                      key_down;
   } result_type;

   // Increment, holding at the top of the range
   function automatic timer_type sat_inc(input timer_type v);
      timer_type r;
      if (v == TIMER_MAX) begin
         r = v;
      end else begin
         r = v + timer_type'(1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/mked_csr.sv =====
`default_nettype none
module mked_csr
   import mked_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Pick the addressed register, keep only its width
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_DEBOUNCE: cfg_in.debounce_ticks = wr_data[DEBOUNCE_W-1:0];
            REG_DOT:      cfg_in.dot_ticks      = wr_data[DOT_W-1:0];
            REG_GAP:      cfg_in.char_gap_ticks = wr_data[GAP_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RST;
         cfg_ff.dot_ticks      <= DOT_RST;
         cfg_ff.char_gap_ticks <= GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== src/mked_core.sv =====
`default_nettype none
module mked_core
   import mked_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       key_raw,
   input  wire cfg_type    cfg,
   output result_type      result
);

   logic                    prev_raw_ff, prev_raw_in;
   logic                    settled_ff, settled_in;
   timer_type               stable_ff, stable_in;
   timer_type               press_ff, press_in;
   timer_type               idle_ff, idle_in;
   logic [MAX_ELEMENTS-1:0] pattern_ff, pattern_in;
   count_type               count_ff, count_in;

   logic                    change;
   logic                    elem_valid;
   logic                    elem_dash;
   logic                    chr_valid;
   logic [MAX_ELEMENTS-1:0] chr_bits;
   count_type               chr_len;

   // Next state and result for one tick
   always_comb begin
      settled_in = settled_ff;
      press_in   = press_ff;
      idle_in    = idle_ff;
      pattern_in = pattern_ff;
      count_in   = count_ff;
      elem_valid = 1'b0;
      elem_dash  = 1'b0;
      chr_valid  = 1'b0;
      chr_bits   = '0;
      chr_len    = '0;
      prev_raw_in = key_raw;

      // advance press or idle timer
      if (!settled_ff) begin
         press_in = sat_inc(press_ff);
      end else begin
         idle_in = sat_inc(idle_ff);
      end

      // debounce counter
      if (key_raw != prev_raw_ff) begin
         stable_in = '0;
      end else begin
         stable_in = sat_inc(stable_ff);
      end

      change = (stable_in > timer_type'(cfg.debounce_ticks)) && (key_raw != settled_ff);

      // accept new level, classify on release
      if (change) begin
         settled_in = key_raw;
         if (!key_raw) begin
            press_in = '0;
         end else begin
            idle_in    = '0;
            elem_valid = 1'b1;
            elem_dash  = !(press_in < {cfg.dot_ticks, 1'b0});
            if (count_ff < count_type'(MAX_ELEMENTS)) begin
               if (elem_dash) begin
                  pattern_in[count_ff[ELEM_IDX_W-1:0]] = 1'b1;
               end
               count_in = count_ff + count_type'(1);
            end
         end
      end

      // character gap: emit and clear
      if (settled_in && (count_in != '0) && (idle_in > cfg.char_gap_ticks)) begin
         chr_valid  = 1'b1;
         chr_bits   = pattern_in;
         chr_len    = count_in;
         pattern_in = '0;
         count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= 1'b1;
         settled_ff  <= 1'b1;
         stable_ff   <= '0;
         press_ff    <= '0;
         idle_ff     <= '0;
         pattern_ff  <= '0;
         count_ff    <= '0;
      end else if (step) begin
         prev_raw_ff <= prev_raw_in;
         settled_ff  <= settled_in;
         stable_ff   <= stable_in;
         press_ff    <= press_in;
         idle_ff     <= idle_in;
         pattern_ff  <= pattern_in;
         count_ff    <= count_in;
      end
   end

   assign result.key_down      = !settled_in;
   assign result.element_valid = elem_valid;
   assign result.element_dash  = elem_dash;
   assign result.char_valid    = chr_valid;
   assign result.pattern_bits  = chr_bits;
   assign result.pattern_len   = chr_len;

endmodule
`default_nettype wire

// ===== src/mked_out_reg.sv =====
`default_nettype none
module mked_out_reg
   import mked_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type result,
   input  wire logic       taken,
   output logic            valid,
   output result_type      data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Hold until taken, reload on every accepted tick
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (taken) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule
`default_nettype wire

// ===== src/morse_key_element_decoder.sv =====
// Straight-key element decoder, one tick per request beat.
// The response to an accepted request beat is registered and offered in the next cycle.
// Throughput: 1 beat per cycle; the single output register is refilled in the
// cycle it is taken, so the request side stalls only while a response waits.
// Reset (synchronous, active high): key open, timers and pattern cleared,
// registers back to debounce 5, dot 60, character gap 180.
`default_nettype none
module morse_key_element_decoder
   import mked_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [0] key_raw, [7:1] zero
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [0] key_down, [1] element_valid,
                                                   // [2] element_dash, [3] char_valid,
                                                   // [11:4] pattern_bits, [15:12] pattern_len
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg;
   result_type core_result;
   result_type out_data;
   logic       req_beat;
   logic       rsp_beat;

   // Accept when the output register is free or being emptied
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;

   mked_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   mked_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (req_beat),
      .key_raw (req_tdata[0]),
      .cfg     (cfg),
      .result  (core_result)
   );

   mked_out_reg u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (req_beat),
      .result (core_result),
      .taken  (rsp_beat),
      .valid  (rsp_tvalid),
      .data   (out_data)
   );

   assign rsp_tdata = out_data;

endmodule
`default_nettype wire
